// ===== hw/rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
// jsu_pkg: shared types, codes and UTF-8 helpers for the JSON string unescaper.
// No dependencies.
package jsu_pkg;

	localparam logic [2:0] PH_PLAIN    = 3'd0;
	localparam logic [2:0] PH_ESC      = 3'd1;
	localparam logic [2:0] PH_HEX      = 3'd2;
	localparam logic [2:0] PH_AH       = 3'd3;
	localparam logic [2:0] PH_AH_ESC   = 3'd4;
	localparam logic [2:0] PH_LOW_HEX  = 3'd5;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [1:0] ERR_UNTERM  = 2'd0;
	localparam logic [1:0] ERR_CTRL    = 2'd1;
	localparam logic [1:0] ERR_ESC     = 2'd2;
	localparam logic [1:0] ERR_UNICODE = 2'd3;

	// second part of a job
	localparam logic [2:0] SEC_NONE = 3'd0;
	localparam logic [2:0] SEC_CP   = 3'd1;
	localparam logic [2:0] SEC_RAW  = 3'd2;
	localparam logic [2:0] SEC_END  = 3'd3;
	localparam logic [2:0] SEC_ERR  = 3'd4;

	localparam int          FIFO_DEPTH = 4;
	localparam int          FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam logic [15:0] SURR_HI_LO = 16'hD800;
	localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
	localparam logic [15:0] SURR_LO_LO = 16'hDC00;
	localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;
	localparam logic [7:0]  CTRL_LIMIT = 8'h20;
	localparam logic [5:0]  HIGH_TAG   = 6'b110110;

	// optional high surrogate (3 bytes), then one second part
	typedef struct packed {
		logic        hi_vld;
		logic [9:0]  hi;
		logic [2:0]  sec_kind;
		logic [20:0] sec_val;
	} job_t;

	function automatic logic [2:0] utf8_len(input logic [20:0] cp);
		if (cp < 21'h80)
			return 3'd1;
		else if (cp < 21'h800)
			return 3'd2;
		else if (cp < 21'h10000)
			return 3'd3;
		else
			return 3'd4;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] j);
		logic [2:0] len;
		len = utf8_len(cp);
		case (len)
			3'd1: return cp[7:0];
			3'd2: return (j == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
			3'd3: begin
				case (j)
					2'd0:    return {4'b1110, cp[15:12]};
					2'd1:    return {2'b10, cp[11:6]};
					default: return {2'b10, cp[5:0]};
				endcase
			end
			default: begin
				case (j)
					2'd0:    return {5'b11110, cp[20:18]};
					2'd1:    return {2'b10, cp[17:12]};
					2'd2:    return {2'b10, cp[11:6]};
					default: return {2'b10, cp[5:0]};
				endcase
			end
		endcase
	endfunction

endpackage

// ===== hw/rtl/jsu_in_if.sv =====
`timescale 1ns / 1ps
// jsu_in_if: input channel, one raw string byte per word.
// No dependencies.
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, in_byte, end_of_text, input ready);
	modport sink (input valid, in_byte, end_of_text, output ready);
endinterface

// ===== hw/rtl/jsu_out_if.sv =====
`timescale 1ns / 1ps
// jsu_out_if: result channel, one decoded byte, end or error per word.
// No dependencies.
interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic [1:0] error_code;
	logic       last;

	modport source (output valid, kind, out_byte, error_code, last, input ready);
	modport sink (input valid, kind, out_byte, error_code, last, output ready);
endinterface

// ===== hw/rtl/jsu_front.sv =====
`timescale 1ns / 1ps
// jsu_front: escape/surrogate FSM; turns each input word into at most one job.
// Depends on jsu_pkg, jsu_in_if.
module jsu_front (
	input  logic          clk,
	input  logic          arst_n,
	jsu_in_if.sink        item,
	input  logic          full,
	output logic          push,
	output jsu_pkg::job_t job
);

	logic [2:0]  phase_q, phase_d;
	logic [1:0]  hc_q, hc_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  pend_q, pend_d;

	logic [7:0]  c;
	logic        eot;
	logic        accept;
	logic [3:0]  dig;
	logic        dig_ok;
	logic        hv;
	logic [15:0] acc_sh;
	logic        sh_high;
	logic        sh_low;

	logic [2:0]  pl_kind;
	logic [20:0] pl_val;
	logic [2:0]  es_kind;
	logic [20:0] es_val;
	logic        es_u;

	assign c          = item.in_byte;
	assign eot        = item.end_of_text;
	assign item.ready = !full;
	assign accept     = item.valid && item.ready;

	always_comb begin
		dig    = 4'd0;
		dig_ok = 1'b1;
		if (c >= 8'h30 && c <= 8'h39)
			dig = 4'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66)
			dig = 4'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46)
			dig = 4'(c - 8'h37);
		else
			dig_ok = 1'b0;
	end

	assign hv      = dig_ok && !eot;
	assign acc_sh  = {acc_q[11:0], dig};
	assign sh_high = (acc_sh >= jsu_pkg::SURR_HI_LO) && (acc_sh <= jsu_pkg::SURR_HI_HI);
	assign sh_low  = (acc_sh >= jsu_pkg::SURR_LO_LO) && (acc_sh <= jsu_pkg::SURR_LO_HI);

	// plain content byte other than backslash
	always_comb begin
		pl_val = 21'd0;
		if (c == 8'h22) begin
			pl_kind = jsu_pkg::SEC_END;
		end else if (c < jsu_pkg::CTRL_LIMIT) begin
			pl_kind = jsu_pkg::SEC_ERR;
			pl_val  = {19'd0, jsu_pkg::ERR_CTRL};
		end else begin
			pl_kind = jsu_pkg::SEC_RAW;
			pl_val  = {13'd0, c};
		end
	end

	// byte after a backslash
	always_comb begin
		es_kind = jsu_pkg::SEC_RAW;
		es_val  = 21'd0;
		es_u    = 1'b0;
		case (c)
			8'h22, 8'h5C, 8'h2F: es_val = {13'd0, c};
			8'h62:               es_val = 21'h08;
			8'h66:               es_val = 21'h0C;
			8'h6E:               es_val = 21'h0A;
			8'h72:               es_val = 21'h0D;
			8'h74:               es_val = 21'h09;
			8'h75: begin
				es_u    = 1'b1;
				es_kind = jsu_pkg::SEC_NONE;
			end
			default: begin
				es_kind = jsu_pkg::SEC_ERR;
				es_val  = {19'd0, jsu_pkg::ERR_ESC};
			end
		endcase
	end

	always_comb begin
		phase_d      = phase_q;
		hc_d         = hc_q;
		acc_d        = acc_q;
		pend_d       = pend_q;
		job.hi_vld   = 1'b0;
		job.hi       = pend_q;
		job.sec_kind = jsu_pkg::SEC_NONE;
		job.sec_val  = 21'd0;
		case (phase_q)
			jsu_pkg::PH_ESC: begin
				phase_d = jsu_pkg::PH_PLAIN;
				if (eot) begin
					job.sec_kind = jsu_pkg::SEC_ERR;
					job.sec_val  = {19'd0, jsu_pkg::ERR_ESC};
				end else if (es_u) begin
					phase_d = jsu_pkg::PH_HEX;
					hc_d    = 2'd0;
					acc_d   = 16'd0;
				end else begin
					job.sec_kind = es_kind;
					job.sec_val  = es_val;
				end
			end
			jsu_pkg::PH_HEX: begin
				if (!hv) begin
					phase_d      = jsu_pkg::PH_PLAIN;
					job.sec_kind = jsu_pkg::SEC_ERR;
					job.sec_val  = {19'd0, jsu_pkg::ERR_UNICODE};
				end else if (hc_q == 2'd3) begin
					hc_d  = 2'd0;
					acc_d = 16'd0;
					if (sh_high) begin
						pend_d  = acc_sh[9:0];
						phase_d = jsu_pkg::PH_AH;
					end else begin
						phase_d      = jsu_pkg::PH_PLAIN;
						job.sec_kind = jsu_pkg::SEC_CP;
						job.sec_val  = {5'd0, acc_sh};
					end
				end else begin
					acc_d = acc_sh;
					hc_d  = hc_q + 2'd1;
				end
			end
			jsu_pkg::PH_AH: begin
				if (eot) begin
					phase_d      = jsu_pkg::PH_PLAIN;
					job.hi_vld   = 1'b1;
					job.sec_kind = jsu_pkg::SEC_ERR;
					job.sec_val  = {19'd0, jsu_pkg::ERR_UNTERM};
				end else if (c == 8'h5C) begin
					phase_d = jsu_pkg::PH_AH_ESC;
				end else begin
					phase_d      = jsu_pkg::PH_PLAIN;
					job.hi_vld   = 1'b1;
					job.sec_kind = pl_kind;
					job.sec_val  = pl_val;
				end
			end
			jsu_pkg::PH_AH_ESC: begin
				if (!eot && es_u) begin
					phase_d = jsu_pkg::PH_LOW_HEX;
					hc_d    = 2'd0;
					acc_d   = 16'd0;
				end else begin
					phase_d    = jsu_pkg::PH_PLAIN;
					job.hi_vld = 1'b1;
					if (eot) begin
						job.sec_kind = jsu_pkg::SEC_ERR;
						job.sec_val  = {19'd0, jsu_pkg::ERR_ESC};
					end else begin
						job.sec_kind = es_kind;
						job.sec_val  = es_val;
					end
				end
			end
			jsu_pkg::PH_LOW_HEX: begin
				if (!hv) begin
					phase_d      = jsu_pkg::PH_PLAIN;
					job.hi_vld   = 1'b1;
					job.sec_kind = jsu_pkg::SEC_ERR;
					job.sec_val  = {19'd0, jsu_pkg::ERR_UNICODE};
				end else if (hc_q != 2'd3) begin
					acc_d = acc_sh;
					hc_d  = hc_q + 2'd1;
				end else begin
					hc_d  = 2'd0;
					acc_d = 16'd0;
					if (sh_low) begin
						phase_d      = jsu_pkg::PH_PLAIN;
						job.sec_kind = jsu_pkg::SEC_CP;
						job.sec_val  = jsu_pkg::SUPP_BASE + {1'b0, pend_q, acc_sh[9:0]};
					end else begin
						job.hi_vld = 1'b1;
						if (sh_high) begin
							pend_d  = acc_sh[9:0];
							phase_d = jsu_pkg::PH_AH;
						end else begin
							phase_d      = jsu_pkg::PH_PLAIN;
							job.sec_kind = jsu_pkg::SEC_CP;
							job.sec_val  = {5'd0, acc_sh};
						end
					end
				end
			end
			default: begin
				phase_d = jsu_pkg::PH_PLAIN;
				if (eot) begin
					job.sec_kind = jsu_pkg::SEC_ERR;
					job.sec_val  = {19'd0, jsu_pkg::ERR_UNTERM};
				end else if (c == 8'h5C) begin
					phase_d = jsu_pkg::PH_ESC;
				end else begin
					job.sec_kind = pl_kind;
					job.sec_val  = pl_val;
				end
			end
		endcase
	end

	assign push = accept && (job.hi_vld || (job.sec_kind != jsu_pkg::SEC_NONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jsu_pkg::PH_PLAIN;
			hc_q    <= 2'd0;
			acc_q   <= 16'd0;
			pend_q  <= 10'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			hc_q    <= hc_d;
			acc_q   <= acc_d;
			pend_q  <= pend_d;
		end
	end

endmodule

// ===== hw/rtl/jsu_job_fifo.sv =====
`timescale 1ns / 1ps
// jsu_job_fifo: short register queue of jobs between front and back.
// Depends on jsu_pkg.
module jsu_job_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jsu_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output jsu_pkg::job_t head
);

	jsu_pkg::job_t                ent_q [jsu_pkg::FIFO_DEPTH];
	logic [jsu_pkg::FIFO_AW-1:0]  wr_q;
	logic [jsu_pkg::FIFO_AW-1:0]  rd_q;
	logic [jsu_pkg::FIFO_AW:0]    cnt_q;

	assign full      = (cnt_q == (jsu_pkg::FIFO_AW+1)'(jsu_pkg::FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// ===== hw/rtl/jsu_back.sv =====
`timescale 1ns / 1ps
// jsu_back: expands jobs into registered result words, one per cycle unless stalled.
// Depends on jsu_pkg, jsu_out_if.
module jsu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          not_empty,
	input  jsu_pkg::job_t head,
	output logic          pop,
	jsu_out_if.source     result
);

	jsu_pkg::job_t cur_q;
	logic          cur_vld_q;
	logic [2:0]    idx_q;

	logic          out_vld_q;
	logic [1:0]    kind_q;
	logic [7:0]    byte_q;
	logic [1:0]    err_q;
	logic          last_q;

	logic          adv;
	logic          emit;
	logic          is_last;
	logic [2:0]    sec_len;
	logic [2:0]    n_res;
	logic [2:0]    j_full;
	logic [20:0]   hi_cp;
	logic [1:0]    r_kind;
	logic [7:0]    r_byte;
	logic [1:0]    r_err;

	assign hi_cp = {5'd0, jsu_pkg::HIGH_TAG, cur_q.hi};

	always_comb begin
		case (cur_q.sec_kind)
			jsu_pkg::SEC_NONE: sec_len = 3'd0;
			jsu_pkg::SEC_CP:   sec_len = jsu_pkg::utf8_len(cur_q.sec_val);
			default:           sec_len = 3'd1;
		endcase
	end

	assign n_res   = (cur_q.hi_vld ? 3'd3 : 3'd0) + sec_len;
	assign is_last = (idx_q == n_res - 3'd1);
	assign j_full  = idx_q - (cur_q.hi_vld ? 3'd3 : 3'd0);

	always_comb begin
		r_kind = jsu_pkg::KIND_DATA;
		r_byte = 8'd0;
		r_err  = jsu_pkg::ERR_UNTERM;
		if (cur_q.hi_vld && idx_q < 3'd3) begin
			r_byte = jsu_pkg::utf8_byte(hi_cp, idx_q[1:0]);
		end else begin
			case (cur_q.sec_kind)
				jsu_pkg::SEC_CP:  r_byte = jsu_pkg::utf8_byte(cur_q.sec_val, j_full[1:0]);
				jsu_pkg::SEC_RAW: r_byte = cur_q.sec_val[7:0];
				jsu_pkg::SEC_END: r_kind = jsu_pkg::KIND_END;
				jsu_pkg::SEC_ERR: begin
					r_kind = jsu_pkg::KIND_ERR;
					r_err  = cur_q.sec_val[1:0];
				end
				default: r_kind = jsu_pkg::KIND_DATA;
			endcase
		end
	end

	assign adv  = !out_vld_q || result.ready;
	assign emit = adv && cur_vld_q;
	assign pop  = not_empty && (!cur_vld_q || (emit && is_last));

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		if (emit) begin
			kind_q <= r_kind;
			byte_q <= r_byte;
			err_q  <= r_err;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= 3'd0;
			out_vld_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_vld_q <= 1'b1;
				idx_q     <= 3'd0;
			end else if (emit && is_last) begin
				cur_vld_q <= 1'b0;
			end else if (emit) begin
				idx_q <= idx_q + 3'd1;
			end
			if (adv)
				out_vld_q <= cur_vld_q;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.kind       = kind_q;
	assign result.out_byte   = byte_q;
	assign result.error_code = err_q;
	assign result.last       = last_q;

endmodule

// ===== hw/rtl/json_string_unescape.sv =====
`timescale 1ns / 1ps
// json_string_unescape: JSON string body to UTF-8 decoder, top level.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if, jsu_front, jsu_job_fifo, jsu_back.
// A word's job passes the job queue and current-job register to the output register.
// Throughput: one input word per cycle while the 4-entry job queue has room; the back
// end sends one result word per cycle while the output is not stalled.
// Reset: arst_n clears decoder state, queue and output register; block starts a new string.
module json_string_unescape (
	input  logic       clk,
	input  logic       arst_n,
	jsu_in_if.sink     item,
	jsu_out_if.source  result
);

	logic          push;
	logic          full;
	logic          pop;
	logic          not_empty;
	jsu_pkg::job_t push_job;
	jsu_pkg::job_t head;

	jsu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.full   (full),
		.push   (push),
		.job    (push_job)
	);

	jsu_job_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== hw/rtl/jsu_checker.sv =====
`timescale 1ns / 1ps
// jsu_checker: port-level assertions for json_string_unescape, bound to the top level.
// Depends on jsu_pkg.
module jsu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] kind,
	input logic [7:0] out_byte,
	input logic [1:0] error_code,
	input logic       last
);

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
			&& $stable(error_code) && $stable(last))
		else $error("result word changed while stalled");

	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == jsu_pkg::KIND_END || kind == jsu_pkg::KIND_ERR) |-> last)
		else $error("end or error word not marked last");

	a_term_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != jsu_pkg::KIND_DATA |-> out_byte == 8'd0)
		else $error("nonzero byte on end or error word");

	a_data_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == jsu_pkg::KIND_DATA || kind == jsu_pkg::KIND_END)
			|-> error_code == jsu_pkg::ERR_UNTERM)
		else $error("error code set on a non-error word");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.kind       (result.kind),
	.out_byte   (result.out_byte),
	.error_code (result.error_code),
	.last       (result.last)
);
